### src/mrev_pkg.sv
// Shared types and constants of the mouse report event engine.
package mrev_pkg;

  localparam int COORD_BITS   = 12;
  localparam int BUTTON_COUNT = 5;
  localparam int DISP_W       = 12;
  localparam int WHEEL_W      = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int ACCEL_NUM    = 18;
  localparam int RECIP_MUL    = 52429;
  localparam int RECIP_SHIFT  = 19;
  localparam int MAG_W        = DISP_W;
  localparam int PROD_W       = 16;
  localparam int RECIP_W      = 17;
  localparam int QUOT_W       = 12;
  localparam int SUM_W        = ((COORD_BITS > QUOT_W) ? COORD_BITS : QUOT_W) + 2;
  localparam int EV_W         = BUTTON_COUNT + 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    EV_MOVE  = 2'd0,
    EV_DOWN  = 2'd1,
    EV_UP    = 2'd2,
    EV_WHEEL = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [EV_W-1:0]         mask;
    logic [BUTTON_COUNT-1:0] buttons;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic [WHEEL_W-1:0]      wheel;
  } report_desc_t;

endpackage

### src/mrev_front.sv
// Front end: accepts reports, scales displacement, updates cursor state, classifies events.
module mrev_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mrev_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrev_pkg::COORD_BITS-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mrev_pkg::BUTTON_COUNT-1:0]   buttons,
  input  logic signed [mrev_pkg::DISP_W-1:0]  disp_x,
  input  logic signed [mrev_pkg::DISP_W-1:0]  disp_y,
  input  logic signed [mrev_pkg::WHEEL_W-1:0] wheel_delta,
  input  logic                                q_full,
  output logic                                q_push,
  output mrev_pkg::report_desc_t              q_desc
);

  logic [mrev_pkg::COORD_BITS-1:0]   width;
  logic [mrev_pkg::COORD_BITS-1:0]   height;
  logic [mrev_pkg::COORD_BITS-1:0]   pos_x;
  logic [mrev_pkg::COORD_BITS-1:0]   pos_y;
  logic [mrev_pkg::BUTTON_COUNT-1:0] prev_btn;

  logic                              a_valid;
  logic [mrev_pkg::BUTTON_COUNT-1:0] a_btn;
  logic [mrev_pkg::WHEEL_W-1:0]      a_wheel;
  logic [mrev_pkg::QUOT_W-1:0]       a_qx;
  logic [mrev_pkg::QUOT_W-1:0]       a_qy;
  logic                              a_negx;
  logic                              a_negy;

  logic                              accept;
  logic                              b_fire;
  logic                              setup;
  logic [mrev_pkg::QUOT_W-1:0]       qx;
  logic [mrev_pkg::QUOT_W-1:0]       qy;
  logic [mrev_pkg::COORD_BITS-1:0]   nx;
  logic [mrev_pkg::COORD_BITS-1:0]   ny;
  logic [mrev_pkg::BUTTON_COUNT-1:0] changed;
  logic                              moved;
  logic                              wheel_nz;
  logic [mrev_pkg::EV_W-1:0]         mask;
  logic [mrev_pkg::COORD_BITS:0]     cfg_inc;

  function automatic logic [mrev_pkg::QUOT_W-1:0] scale_mag(
    input logic [mrev_pkg::DISP_W-1:0] d
  );
    logic [mrev_pkg::MAG_W-1:0]                          mag;
    logic [mrev_pkg::PROD_W-1:0]                         p18;
    logic [mrev_pkg::PROD_W+mrev_pkg::RECIP_W-1:0]       pq;
    mag = d[mrev_pkg::DISP_W-1] ? (~d + mrev_pkg::MAG_W'(1)) : d;
    p18 = mrev_pkg::PROD_W'(mag) * mrev_pkg::PROD_W'(mrev_pkg::ACCEL_NUM);
    pq  = (mrev_pkg::PROD_W+mrev_pkg::RECIP_W)'(p18)
        * (mrev_pkg::PROD_W+mrev_pkg::RECIP_W)'(mrev_pkg::RECIP_MUL);
    return pq[mrev_pkg::RECIP_SHIFT +: mrev_pkg::QUOT_W];
  endfunction

  function automatic logic [mrev_pkg::COORD_BITS-1:0] move_axis(
    input logic [mrev_pkg::COORD_BITS-1:0] pos,
    input logic [mrev_pkg::QUOT_W-1:0]     q,
    input logic                            neg,
    input logic [mrev_pkg::COORD_BITS-1:0] size
  );
    logic signed [mrev_pkg::SUM_W-1:0] step;
    logic signed [mrev_pkg::SUM_W-1:0] np;
    step = neg ? -$signed(mrev_pkg::SUM_W'(q)) : $signed(mrev_pkg::SUM_W'(q));
    np   = $signed(mrev_pkg::SUM_W'(pos)) + step;
    if (np[mrev_pkg::SUM_W-1] || (np >= $signed(mrev_pkg::SUM_W'(size)))) begin
      return pos;
    end
    return np[mrev_pkg::COORD_BITS-1:0];
  endfunction

  assign in_stall = a_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign b_fire   = a_valid && !q_full;
  assign setup    = (width != '0) && (height != '0);
  assign qx       = scale_mag(disp_x);
  assign qy       = scale_mag(disp_y);
  assign cfg_inc  = {1'b0, cfg_data} + (mrev_pkg::COORD_BITS+1)'(1);

  always_comb begin
    nx       = move_axis(pos_x, a_qx, a_negx, width);
    ny       = move_axis(pos_y, a_qy, a_negy, height);
    moved    = (nx != pos_x) || (ny != pos_y);
    changed  = prev_btn ^ a_btn;
    wheel_nz = a_wheel != '0;
    mask     = {wheel_nz, changed, moved};
    q_push   = b_fire && setup && (mask != '0);
    q_desc.mask    = mask;
    q_desc.buttons = a_btn;
    q_desc.x       = nx;
    q_desc.y       = ny;
    q_desc.wheel   = a_wheel;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_btn   <= buttons;
      a_wheel <= wheel_delta;
      a_qx    <= qx;
      a_qy    <= qy;
      a_negx  <= disp_x[mrev_pkg::DISP_W-1];
      a_negy  <= disp_y[mrev_pkg::DISP_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      width    <= '0;
      height   <= '0;
      pos_x    <= '0;
      pos_y    <= '0;
      prev_btn <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (b_fire) begin
        a_valid <= 1'b0;
      end
      if (b_fire && setup) begin
        pos_x    <= nx;
        pos_y    <= ny;
        prev_btn <= a_btn;
      end
      if (cfg_we) begin
        case (cfg_index)
          mrev_pkg::REG_WIDTH: begin
            width <= cfg_data;
            pos_x <= cfg_inc[mrev_pkg::COORD_BITS:1];
          end
          mrev_pkg::REG_HEIGHT: begin
            height <= cfg_data;
            pos_y  <= cfg_inc[mrev_pkg::COORD_BITS:1];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### src/mrev_queue.sv
// Two-entry queue of classified reports between front and back end.
module mrev_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mrev_pkg::report_desc_t push_desc,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output mrev_pkg::report_desc_t head
);

  mrev_pkg::report_desc_t store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/mrev_back.sv
// Back end: walks each report's event mask and emits one event per cycle while out_stall does not hold the output.
module mrev_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  mrev_pkg::report_desc_t               q_head,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mrev_pkg::event_kind_t                event_kind,
  output logic [mrev_pkg::BUTTON_COUNT-1:0]    event_buttons,
  output logic [mrev_pkg::COORD_BITS-1:0]      cursor_x,
  output logic [mrev_pkg::COORD_BITS-1:0]      cursor_y,
  output logic signed [mrev_pkg::WHEEL_W-1:0]  wheel_out,
  output logic                                 last_event
);

  mrev_pkg::report_desc_t    cur;
  logic                      cur_valid;
  logic [mrev_pkg::EV_W-1:0] rem;

  logic                              out_load;
  logic [mrev_pkg::EV_W-1:0]         pick;
  logic [mrev_pkg::EV_W-1:0]         rem_next;
  logic                              cur_done;
  logic [mrev_pkg::BUTTON_COUNT-1:0] btn_pick;
  mrev_pkg::event_kind_t             kind;
  logic [mrev_pkg::BUTTON_COUNT-1:0] ev_btn;

  always_comb begin
    out_load = !out_valid || !out_stall;
    pick     = rem & (~rem + mrev_pkg::EV_W'(1));
    rem_next = rem & ~pick;
    cur_done = out_load && cur_valid && (rem_next == '0);
    q_pop    = q_valid && (!cur_valid || cur_done);
    btn_pick = pick[mrev_pkg::BUTTON_COUNT:1];
    if (pick[0]) begin
      kind   = mrev_pkg::EV_MOVE;
      ev_btn = cur.buttons;
    end else if (pick[mrev_pkg::EV_W-1]) begin
      kind   = mrev_pkg::EV_WHEEL;
      ev_btn = cur.buttons;
    end else begin
      kind   = ((cur.buttons & btn_pick) != '0) ? mrev_pkg::EV_DOWN : mrev_pkg::EV_UP;
      ev_btn = btn_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (out_load && cur_valid) begin
      event_kind    <= kind;
      event_buttons <= ev_btn;
      cursor_x      <= cur.x;
      cursor_y      <= cur.y;
      wheel_out     <= cur.wheel;
      last_event    <= rem_next == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= cur_valid;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        rem       <= q_head.mask;
      end else begin
        if (cur_done) begin
          cur_valid <= 1'b0;
        end
        if (out_load && cur_valid) begin
          rem <= rem_next;
        end
      end
    end
  end

endmodule

### src/mouse_report_event_engine_top.sv
// Top level of the mouse report event engine.
// Each report runs through a two-stage front end (displacement scaling by 18/10, then the
// per-axis position update and event classification), a two-entry queue and a back end
// that emits one event per cycle from an output register while out_stall is low. A report
// producing n events (0 to 7) holds the back end for its n events, and the back end takes
// the next report as its last event is loaded, so the single event output port sets the
// sustained report rate. Reports are dropped while either screen dimension is zero, and
// writing a dimension recenters that axis.
module mouse_report_event_engine_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mrev_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrev_pkg::COORD_BITS-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mrev_pkg::BUTTON_COUNT-1:0]    buttons,
  input  logic signed [mrev_pkg::DISP_W-1:0]   disp_x,
  input  logic signed [mrev_pkg::DISP_W-1:0]   disp_y,
  input  logic signed [mrev_pkg::WHEEL_W-1:0]  wheel_delta,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           event_kind,
  output logic [mrev_pkg::BUTTON_COUNT-1:0]    event_buttons,
  output logic [mrev_pkg::COORD_BITS-1:0]      cursor_x,
  output logic [mrev_pkg::COORD_BITS-1:0]      cursor_y,
  output logic signed [mrev_pkg::WHEEL_W-1:0]  wheel_out,
  output logic                                 last_event
);

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  mrev_pkg::report_desc_t q_desc;
  mrev_pkg::report_desc_t q_head;
  mrev_pkg::event_kind_t  kind;

  assign event_kind = kind;

  mrev_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .buttons     (buttons),
    .disp_x      (disp_x),
    .disp_y      (disp_y),
    .wheel_delta (wheel_delta),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_desc      (q_desc)
  );

  mrev_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (q_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  mrev_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (kind),
    .event_buttons (event_buttons),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .wheel_out     (wheel_out),
    .last_event    (last_event)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("item pushed into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("item popped from empty queue");

  a_push_mask: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_desc.mask != '0))
    else $error("queued item carries no event");

endmodule

### test/tb_mouse_report_event_engine_top.sv
// Testbench for the mouse report event engine: directed and random reports checked against a cursor model.
`timescale 1ns / 100ps

module tb_mouse_report_event_engine_top;
  import mrev_pkg::*;

  localparam int ACCEL_DEN      = 10;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef struct packed {
    logic [BUTTON_COUNT-1:0] buttons;
    logic [DISP_W-1:0]       dx;
    logic [DISP_W-1:0]       dy;
    logic [WHEEL_W-1:0]      wheel;
  } report_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [BUTTON_COUNT-1:0] btn;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic [WHEEL_W-1:0]      wheel;
    logic                    last;
  } mouse_event_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [COORD_BITS-1:0]       cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [BUTTON_COUNT-1:0]     buttons = '0;
  logic signed [DISP_W-1:0]    disp_x = '0;
  logic signed [DISP_W-1:0]    disp_y = '0;
  logic signed [WHEEL_W-1:0]   wheel_delta = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  event_kind;
  logic [BUTTON_COUNT-1:0]     event_buttons;
  logic [COORD_BITS-1:0]       cursor_x;
  logic [COORD_BITS-1:0]       cursor_y;
  logic signed [WHEEL_W-1:0]   wheel_out;
  logic                        last_event;

  report_t      pending_reports[$];
  mouse_event_t events_due[$];
  report_t      cur_report;

  int scr_w = 0;
  int scr_h = 0;
  int cur_x = 0;
  int cur_y = 0;
  logic [BUTTON_COUNT-1:0] held_buttons = '0;
  logic [BUTTON_COUNT-1:0] last_queued = '0;

  int reports_sent = 0;
  int reports_taken = 0;
  int fail_count = 0;
  int in_run = 0;
  int in_gap = 0;
  int out_run = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  mouse_report_event_engine_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .buttons       (buttons),
    .disp_x        (disp_x),
    .disp_y        (disp_y),
    .wheel_delta   (wheel_delta),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .event_buttons (event_buttons),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .wheel_out     (wheel_out),
    .last_event    (last_event)
  );

  always #5 clk = ~clk;

  task automatic draw_wait(inout int run, output int n);
    if (run > 0) begin
      run--;
      n = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(8, 24);
      n = 0;
    end else begin
      n = $urandom_range(0, 8);
    end
  endtask

  function automatic mouse_event_t make_event(input logic [1:0] kind,
                                              input logic [BUTTON_COUNT-1:0] btn,
                                              input logic [WHEEL_W-1:0] wheel);
    mouse_event_t e;
    e.kind  = kind;
    e.btn   = btn;
    e.x     = COORD_BITS'(cur_x);
    e.y     = COORD_BITS'(cur_y);
    e.wheel = wheel;
    e.last  = 1'b0;
    return e;
  endfunction

  task automatic predict_report(input report_t r);
    int sx, sy, nx, ny, old_x, old_y;
    logic [BUTTON_COUNT-1:0] flips, bit_m;
    mouse_event_t burst[$];
    if (scr_w == 0 || scr_h == 0) return;
    old_x = cur_x;
    old_y = cur_y;
    sx = $signed(r.dx);
    sy = $signed(r.dy);
    nx = cur_x + sx * ACCEL_NUM / ACCEL_DEN;
    ny = cur_y + sy * ACCEL_NUM / ACCEL_DEN;
    if (nx >= 0 && nx < scr_w) cur_x = nx;
    if (ny >= 0 && ny < scr_h) cur_y = ny;
    if (cur_x != old_x || cur_y != old_y) burst.push_back(make_event(EV_MOVE, r.buttons, r.wheel));
    flips = held_buttons ^ r.buttons;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      bit_m = '0;
      bit_m[i] = 1'b1;
      if (flips[i]) burst.push_back(make_event(r.buttons[i] ? EV_DOWN : EV_UP, bit_m, r.wheel));
    end
    if (r.wheel != '0) burst.push_back(make_event(EV_WHEEL, r.buttons, r.wheel));
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[k]) events_due.push_back(burst[k]);
    held_buttons = r.buttons;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_report(cur_report);
        reports_taken++;
        draw_wait(in_run, in_gap);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reports.size() > 0) begin
        cur_report = pending_reports.pop_front();
        buttons     <= cur_report.buttons;
        disp_x      <= cur_report.dx;
        disp_y      <= cur_report.dy;
        wheel_delta <= cur_report.wheel;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mouse_event_t want;
    int n;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (events_due.size() == 0) begin
        $error("unexpected event: kind %0d buttons %0d x %0d y %0d",
               event_kind, event_buttons, cursor_x, cursor_y);
        fail_count++;
      end else begin
        want = events_due.pop_front();
        check_field("event_kind", want.kind, event_kind);
        check_field("event_buttons", want.btn, event_buttons);
        check_field("cursor_x", want.x, cursor_x);
        check_field("cursor_y", want.y, cursor_y);
        check_field("wheel_out", want.wheel, $unsigned(wheel_out));
        check_field("last_event", want.last, last_event);
      end
      draw_wait(out_run, n);
      stall_left = n;
      out_stall <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) begin
      scr_w = val;
      cur_x = (int'(val) + 1) / 2;
    end else if (idx == REG_HEIGHT) begin
      scr_h = val;
      cur_y = (int'(val) + 1) / 2;
    end
  endtask

  task automatic queue_report(input logic [BUTTON_COUNT-1:0] b, input int dx, input int dy,
                              input int w);
    report_t r;
    r.buttons = b;
    r.dx      = DISP_W'(dx);
    r.dy      = DISP_W'(dy);
    r.wheel   = WHEEL_W'(w);
    pending_reports.push_back(r);
    last_queued = b;
    reports_sent++;
  endtask

  task automatic wait_idle();
    while (!(reports_taken == reports_sent && events_due.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int draw_disp();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return int'($urandom_range(0, 16)) - 8;
      2: return int'($urandom_range(0, 400)) - 200;
      3: return $urandom_range(0, 1) ? -2048 : 2047;
      default: return $signed(DISP_W'($urandom));
    endcase
  endfunction

  initial begin
    int w, h, count;
    logic [BUTTON_COUNT-1:0] b;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // not set up: drop everything
    queue_report(5'h1f, 100, 100, 5);
    queue_report(5'h00, -2048, 2047, -128);
    wait_idle();
    write_reg(REG_WIDTH, 12'd640);
    queue_report(5'h03, 10, 10, 1);
    wait_idle();

    write_reg(REG_HEIGHT, 12'd480);
    write_reg(REG_SPARE_LO, COORD_BITS'($urandom));
    write_reg(REG_SPARE_HI, 12'hfff);
    queue_report(5'h00, 0, 0, 0);
    queue_report(5'h01, 1, 1, 0);
    queue_report(5'h00, -1, -1, 0);
    queue_report(5'h1f, 0, 0, 127);
    queue_report(5'h00, 2047, 0, -128);
    queue_report(5'h15, -2048, 5, 1);
    queue_report(5'h15, 5, -2048, 0);
    queue_report(5'h15, 0, 0, 0);
    queue_report(5'h0a, 7, -7, -1);
    queue_report(5'h0a, 3, 0, 0);
    queue_report(5'h0a, -3, 0, 0);
    wait_idle();

    write_reg(REG_WIDTH, 12'd1);
    write_reg(REG_HEIGHT, 12'd1);
    queue_report(5'h00, -1, -1, 0);
    queue_report(5'h00, 1, 1, 0);
    wait_idle();

    write_reg(REG_WIDTH, 12'hfff);
    write_reg(REG_HEIGHT, 12'hfff);
    queue_report(5'h00, 2047, 2047, 0);
    queue_report(5'h1f, 1137, -1137, 0);
    queue_report(5'h00, -2048, 2047, 0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 5: begin w = $urandom_range(1, 4095); h = $urandom_range(1, 4095); end
        1: begin w = $urandom_range(2, 24); h = $urandom_range(2, 24); end
        2: begin w = 0; h = scr_h; end
        3: begin w = 4095; h = 1; end
        default: begin w = 1; h = 4095; end
      endcase
      write_reg(REG_WIDTH, COORD_BITS'(w));
      if (ph != 2) write_reg(REG_HEIGHT, COORD_BITS'(h));
      count = (ph == 2) ? 8 : 25;
      for (int k = 0; k < count; k++) begin
        b = ($urandom_range(0, 9) < 6) ? last_queued : BUTTON_COUNT'($urandom);
        queue_report(b, draw_disp(), draw_disp(),
                     $urandom_range(0, 1) ? 0 : $signed(WHEEL_W'($urandom)));
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
